/* rtl/dds_spg_pkg.sv */
package dds_spg_pkg;

    // Field and register widths
    localparam int CMD_W      = 32;
    localparam int SCALE_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = CMD_W + SCALE_W - FRAC_W;
    localparam int POS_W      = 32;
    localparam int STEP_BIT_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_BIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_SCALE = 1'd1;

    // Register reset values
    localparam logic [STEP_BIT_W-1:0] STEP_BIT_RST   = 5'd22;
    localparam logic [SCALE_W-1:0]    FREQ_SCALE_RST = 32'd6871948;

    // Saturation limits of the add magnitude
    localparam logic [CMD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [CMD_W-1:0] SAT_NEG = 32'h8000_0000;

    // Input request
    typedef struct packed {
        logic                    joint_enable;
        logic signed [CMD_W-1:0] freq_cmd;
    } in_item_t;

    // Result request
    typedef struct packed {
        logic                    step_out;
        logic                    dir_out;
        logic                    driver_disable;
        logic signed [POS_W-1:0] position;
    } out_item_t;

    // Scaled request passed from the multiplier to the accumulator
    typedef struct packed {
        logic              en;
        logic              neg;
        logic [PROD_W-1:0] prod;
    } scaled_t;

endpackage

/* rtl/dds_step_pulse_generator_unit.sv */
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  in_data   (in_item_t)
// out       source     out_valid / out_stall out_data (out_item_t)
// cfg       sink       cfg_we               cfg_index, cfg_data
//
// One request is taken per cycle while in_stall is low; its result passes the
// input, magnitude, product and result registers in order before it is offered.
// Accumulator and position close their loop in the result stage.
// Reset empties the pipeline, zeroes accumulator and position, sets direction
// forward and driver disable high, and loads the register defaults.
// A result-side stall backs up stage by stage; empty stages still take requests.
module dds_step_pulse_generator_unit
    import dds_spg_pkg::*;
#(
    parameter int ACC_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [STEP_BIT_W-1:0] step_bit_reg;
    logic [SCALE_W-1:0]    freq_scale_reg;

    logic                  sc_valid;
    logic                  sc_stall;
    scaled_t               sc_data;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_bit_reg   <= STEP_BIT_RST;
            freq_scale_reg <= FREQ_SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEP_BIT:
                begin
                    step_bit_reg <= cfg_data[STEP_BIT_W-1:0];
                end
                CFG_FREQ_SCALE:
                begin
                    freq_scale_reg <= cfg_data[SCALE_W-1:0];
                end
                default:
                begin
                    step_bit_reg <= step_bit_reg;
                end
            endcase
        end
    end

    dds_spg_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .freq_scale (freq_scale_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .sc_valid   (sc_valid),
        .sc_stall   (sc_stall),
        .sc_data    (sc_data)
    );

    dds_spg_accum #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_bit  (step_bit_reg),
        .sc_valid  (sc_valid),
        .sc_stall  (sc_stall),
        .sc_data   (sc_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* rtl/dds_spg_scale.sv */
module dds_spg_scale
    import dds_spg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SCALE_W-1:0] freq_scale,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    output logic               sc_valid,
    input  logic               sc_stall,
    output scaled_t            sc_data
);

    logic                a_valid_reg;
    in_item_t            a_item_reg;
    logic                b_valid_reg;
    logic                b_en_reg;
    logic                b_neg_reg;
    logic [CMD_W-1:0]    b_mag_reg;
    logic                c_valid_reg;
    scaled_t             c_data_reg;

    logic                a_free;
    logic                b_free;
    logic                c_free;
    logic                a_neg;
    logic [CMD_W-1:0]    a_mag;
    logic [CMD_W+SCALE_W-1:0] b_full;

    // Free when empty or when the next stage takes the request
    assign c_free   = !c_valid_reg || !sc_stall;
    assign b_free   = !b_valid_reg || c_free;
    assign a_free   = !a_valid_reg || b_free;
    assign in_stall = !a_free;

    // Magnitude of the command, the most negative value maps to 2^31
    assign a_neg = a_item_reg.freq_cmd[CMD_W-1];
    assign a_mag = a_neg ? (CMD_W'(0) - a_item_reg.freq_cmd) : a_item_reg.freq_cmd;

    // Unsigned product of magnitude and scale
    assign b_full = {{SCALE_W{1'b0}}, b_mag_reg} * {{CMD_W{1'b0}}, freq_scale};

    // Hold control flags of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_free)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // Advance payloads
    always_ff @(posedge clk)
    begin
        if (a_free && in_valid)
        begin
            a_item_reg <= in_data;
        end
        if (b_free && a_valid_reg)
        begin
            b_en_reg  <= a_item_reg.joint_enable;
            b_neg_reg <= a_neg;
            b_mag_reg <= a_mag;
        end
        if (c_free && b_valid_reg)
        begin
            c_data_reg.en   <= b_en_reg;
            c_data_reg.neg  <= b_neg_reg;
            c_data_reg.prod <= b_full[CMD_W+SCALE_W-1:FRAC_W];
        end
    end

    assign sc_valid = c_valid_reg;
    assign sc_data  = c_data_reg;

endmodule

/* rtl/dds_spg_accum.sv */
module dds_spg_accum
    import dds_spg_pkg::*;
#(
    parameter int ACC_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [STEP_BIT_W-1:0] step_bit,
    input  logic                  sc_valid,
    output logic                  sc_stall,
    input  scaled_t               sc_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    logic [ACC_WIDTH-1:0] phase_acc_reg;
    logic [ACC_WIDTH-1:0] phase_acc_next;
    logic [POS_W-1:0]     step_count_reg;
    logic [POS_W-1:0]     step_count_next;
    logic                 last_dir_reg;
    logic                 last_dir_next;
    logic                 drive_off_reg;
    logic                 drive_off_next;
    logic                 out_valid_reg;
    out_item_t            out_data_reg;

    logic                 fire;
    logic [CMD_W-1:0]     sat_mag;
    logic [63:0]          mag_wide;
    logic [ACC_WIDTH-1:0] add_mag;
    logic                 dir_now;
    logic [ACC_WIDTH-1:0] toggled;
    logic [ACC_WIDTH-1:0] tog_shift;
    logic                 step_now;

    assign sc_stall = out_valid_reg && out_stall;
    assign fire     = sc_valid && !sc_stall;

    // Saturate the scaled magnitude
    always_comb
    begin
        if (sc_data.neg)
        begin
            sat_mag = (sc_data.prod > PROD_W'(SAT_NEG)) ? SAT_NEG : sc_data.prod[CMD_W-1:0];
        end
        else
        begin
            sat_mag = (sc_data.prod > PROD_W'(SAT_POS)) ? SAT_POS : sc_data.prod[CMD_W-1:0];
        end
    end

    assign mag_wide = {32'b0, sat_mag};
    assign add_mag  = mag_wide[ACC_WIDTH-1:0];
    assign dir_now  = !sc_data.neg && (sat_mag != '0);

    // Accumulate, detect the step bit toggle, update direction and count
    always_comb
    begin
        phase_acc_next  = phase_acc_reg;
        step_count_next = step_count_reg;
        last_dir_next   = last_dir_reg;
        drive_off_next  = 1'b1;
        step_now        = 1'b0;
        toggled         = '0;
        tog_shift       = '0;
        if (sc_data.en)
        begin
            drive_off_next = 1'b0;
            phase_acc_next = sc_data.neg ? (phase_acc_reg - add_mag)
                                         : (phase_acc_reg + add_mag);
            toggled   = phase_acc_reg ^ phase_acc_next;
            tog_shift = toggled >> step_bit;
            if (last_dir_reg != dir_now)
            begin
                last_dir_next = dir_now;
            end
            else if (tog_shift[0])
            begin
                step_now        = 1'b1;
                step_count_next = dir_now ? (step_count_reg + POS_W'(1))
                                          : (step_count_reg - POS_W'(1));
            end
        end
    end

    // Hold joint state and the result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg  <= '0;
            step_count_reg <= '0;
            last_dir_reg   <= 1'b1;
            drive_off_reg  <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_acc_reg  <= phase_acc_next;
                step_count_reg <= step_count_next;
                last_dir_reg   <= last_dir_next;
                drive_off_reg  <= drive_off_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    // Load the result request
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg.step_out       <= step_now;
            out_data_reg.dir_out        <= last_dir_next;
            out_data_reg.driver_disable <= drive_off_next;
            out_data_reg.position       <= step_count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A step is never issued on a disabled tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.step_out && out_data_reg.driver_disable))
        else $error("step issued with driver disabled");

    // A tick without a step leaves the position alone
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !step_now |=> $stable(step_count_reg))
        else $error("position moved without a step");

    // A direction change suppresses that tick's step
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && sc_data.en && (dir_now != last_dir_reg) |=> !out_data_reg.step_out)
        else $error("step issued on a direction change");

    // A disabled tick holds the accumulator
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !sc_data.en |=> $stable(phase_acc_reg) && drive_off_reg)
        else $error("accumulator moved on a disabled tick");

endmodule

/* bench/dds_spg_checker.sv */
module dds_spg_checker
    import dds_spg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the registers and of the joint state
    logic [STEP_BIT_W-1:0] step_sel;
    logic [SCALE_W-1:0]    scale_q;
    logic [31:0]           phase_acc;
    logic [POS_W-1:0]      step_pos;
    logic                  last_dir;
    logic                  drive_off;

    out_item_t tick_results_q[$];
    int        misses = 0;

    // Advance the joint by one tick and return the result it produces
    function automatic out_item_t advance_joint(input in_item_t rq);
        logic        neg;
        logic [31:0] mag;
        logic [63:0] prod;
        logic [31:0] add;
        logic        dir;
        logic [31:0] acc_next;
        logic [31:0] toggled;
        out_item_t   res;
        res = '0;
        if (rq.joint_enable) begin
            neg = rq.freq_cmd[CMD_W-1];
            mag = neg ? 32'd0 - $unsigned(rq.freq_cmd) : $unsigned(rq.freq_cmd);
            prod = ({32'd0, mag} * {32'd0, scale_q}) >> FRAC_W;
            // Clamp the magnitude, negative side reaches one further
            if (neg) begin
                if (prod > 64'h8000_0000)
                    prod = 64'h8000_0000;
                add = 32'd0 - prod[31:0];
                dir = 1'b0;
            end
            else begin
                if (prod > 64'h7FFF_FFFF)
                    prod = 64'h7FFF_FFFF;
                add = prod[31:0];
                dir = (prod != 64'd0);
            end
            acc_next = phase_acc + add;
            toggled = phase_acc ^ acc_next;
            drive_off = 1'b0;
            // A turn of direction swallows the step of that tick
            if (last_dir != dir)
                last_dir = dir;
            else if (toggled[step_sel]) begin
                res.step_out = 1'b1;
                step_pos = dir ? step_pos + 1 : step_pos - 1;
            end
            phase_acc = acc_next;
        end
        else
            drive_off = 1'b1;
        res.dir_out        = last_dir;
        res.driver_disable = drive_off;
        res.position       = step_pos;
        return res;
    endfunction

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        misses++;
    endtask

    // Track registers, predict on each accepted request, compare each result
    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        if (!rst_n) begin
            step_sel  = STEP_BIT_RST;
            scale_q   = FREQ_SCALE_RST;
            phase_acc = '0;
            step_pos  = '0;
            last_dir  = 1'b1;
            drive_off = 1'b1;
            tick_results_q.delete();
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_STEP_BIT)
                    step_sel = cfg_data[STEP_BIT_W-1:0];
                else if (cfg_index == CFG_FREQ_SCALE)
                    scale_q = cfg_data[SCALE_W-1:0];
            end
            if (in_valid && !in_stall)
                tick_results_q.push_back(advance_joint(in_data));
            if (out_valid && !out_stall) begin
                if (tick_results_q.size() == 0) begin
                    $display("%0t: unexpected result %0h", $time, out_data);
                    misses++;
                end
                else begin
                    want = tick_results_q.pop_front();
                    if (out_data.step_out !== want.step_out)
                        flag_field("step_out", 32'(want.step_out),
                                   32'(out_data.step_out));
                    if (out_data.dir_out !== want.dir_out)
                        flag_field("dir_out", 32'(want.dir_out),
                                   32'(out_data.dir_out));
                    if (out_data.driver_disable !== want.driver_disable)
                        flag_field("driver_disable", 32'(want.driver_disable),
                                   32'(out_data.driver_disable));
                    if (out_data.position !== want.position)
                        flag_field("position", want.position, out_data.position);
                end
            end
        end
        pending    <= tick_results_q.size();
        fail_count <= misses;
    end

endmodule

/* bench/tb_dds_step_pulse_generator_unit.sv */
module tb_dds_step_pulse_generator_unit;
    import dds_spg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICKS_PER_SETTING = 180;
    localparam int STALL_PCT         = 13;
    localparam int HOLD_CYCLES       = 80;
    localparam int WATCHDOG_LIMIT    = 2000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_STEP_BIT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    int   hold_left = 0;
    logic quiet = 1'b0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;

    always #4 clk = ~clk;

    dds_step_pulse_generator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dds_spg_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: random stalls, one long hold-off on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_go && !hold_done) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < STALL_PCT);
    end

    // Drop the run if nothing moves on either channel for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_dds_step_pulse_generator_unit: done, errors");
            $finish;
        end
    end

    // Offer one tick request, with random gaps, and hold it until taken
    task automatic send_tick(input logic en, input logic [CMD_W-1:0] cmd);
        while (!quiet && $urandom_range(0, 99) < STALL_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{joint_enable: en, freq_cmd: cmd};
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stop offering and wait until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic load_regs(input logic [CFG_DATA_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] scale);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_STEP_BIT;
        cfg_data  <= sel;
        @(posedge clk);
        cfg_index <= CFG_FREQ_SCALE;
        cfg_data  <= scale;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] sel_set [6];
        logic [CFG_DATA_W-1:0] scale_set [6];
        logic                  go_neg;
        logic                  en;
        logic [CMD_W-1:0]      cmd;
        logic [CMD_W-1:0]      mag;
        int                    pick;

        sel_set   = '{32'd0, 32'hFFFF_FFFF, 32'd30, $urandom, $urandom, 32'd22};
        scale_set = '{32'h0001_0000, 32'hFFFF_FFFF, 32'd0, $urandom, 32'd1,
                      FREQ_SCALE_RST};
        go_neg = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks at the reset settings
        send_tick(1'b0, 32'd0);
        send_tick(1'b0, 32'h7FFF_FFFF);
        send_tick(1'b1, 32'd0);                  // zero add turns to reverse
        send_tick(1'b1, 32'd40000);              // turn forward, no step
        repeat (4) send_tick(1'b1, 32'd40000);   // roughly one step per tick
        send_tick(1'b1, 32'h7FFF_FFFF);          // positive clamp
        send_tick(1'b1, 32'd1);
        send_tick(1'b1, 32'hFFFF_FFFF);          // minus one, turn reverse
        send_tick(1'b1, 32'h8000_0000);          // negative clamp
        repeat (3) send_tick(1'b1, -32'sd40000);
        send_tick(1'b0, -32'sd40000);            // disabled mid-run
        send_tick(1'b1, -32'sd40000);
        send_tick(1'b1, 32'h8000_0001);
        send_tick(1'b1, 32'h0000_FFFF);

        // Random ticks over a series of register settings
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            load_regs(sel_set[ph], scale_set[ph]);
            quiet <= (ph == 3);
            if (ph == 1)
                hold_go <= 1'b1;
            for (int k = 0; k < TICKS_PER_SETTING; k++) begin
                en = ($urandom_range(0, 99) >= 12);
                // Keep the sign for runs of ticks so that steps build up
                if ($urandom_range(0, 99) < 10)
                    go_neg = !go_neg;
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    case ($urandom_range(0, 4))
                        0: cmd = 32'd0;
                        1: cmd = 32'd1;
                        2: cmd = 32'hFFFF_FFFF;
                        3: cmd = 32'h7FFF_FFFF;
                        default: cmd = 32'h8000_0000;
                    endcase
                end
                else if (pick < 10)
                    cmd = $urandom;
                else begin
                    mag = $urandom >> $urandom_range(0, 31);
                    cmd = go_neg ? 32'd0 - mag : mag;
                end
                send_tick(en, cmd);
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_dds_step_pulse_generator_unit: done, clean");
        else
            $display("tb_dds_step_pulse_generator_unit: done, errors");
        $finish;
    end

endmodule
